>>> sv/thb_pkg.sv
// Shared constants and types for the timestamp history buffer.
package thb_pkg;

    localparam int DEPTH       = 64;
    localparam int IDX_W       = $clog2(DEPTH);
    localparam int CNT_W       = IDX_W + 1;
    localparam int TIME_W      = 63;
    localparam int PAY_W       = 32;
    localparam int AGE_W       = 32;
    localparam int STATUS_W    = 2;
    localparam logic [AGE_W-1:0] MAX_AGE_RST = AGE_W'(5000000);

    typedef enum logic [1:0] {
        OP_APPEND = 2'd0,
        OP_PRUNE  = 2'd1,
        OP_LOOKUP = 2'd2,
        OP_CLEAR  = 2'd3
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK        = 2'd0,
        STAT_EMPTY     = 2'd1,
        STAT_OVERWRITE = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_APP_RD,
        S_APP_WR,
        S_SRCH,
        S_CMP,
        S_NEAR_LO,
        S_NEAR_HI,
        S_NEAR_SEL,
        S_FETCH,
        S_REPLY
    } t_state;

endpackage

>>> sv/timestamp_history_buffer_top.sv
// Timestamp history buffer: a ring of time-ordered entries with append, prune, lookup and clear.
// One word is taken when start is high and busy is low, and exactly one result word follows,
// shown for a single cycle with o_valid; the receiver cannot stall it. Clear, a prune whose
// time does not exceed max_age, and a lookup on an empty history answer on the next cycle.
// Append reads the latest entry before writing when the history is not empty. Prune and
// lookup run a binary search on one shared compare unit over the single read port of the entry
// memory, with a read and a compare per probe and seven probes at most for 64 entries; a lookup
// then selects the nearest entry and does a final read. Configuration writes to max_age take
// effect at once and must occur while idle.
module timestamp_history_buffer_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [1:0]                     i_operation,
    input  logic [thb_pkg::TIME_W-1:0]     i_timestamp,
    input  logic [thb_pkg::PAY_W-1:0]      i_payload,
    input  logic                           i_cfg_we,
    input  logic [thb_pkg::AGE_W-1:0]      i_cfg_data,
    output logic                           o_valid,
    output logic [thb_pkg::STATUS_W-1:0]   o_status,
    output logic [thb_pkg::TIME_W-1:0]     o_found_time,
    output logic [thb_pkg::PAY_W-1:0]      o_found_payload,
    output logic [thb_pkg::CNT_W-1:0]      o_entry_count,
    output logic [thb_pkg::CNT_W-1:0]      o_removed_count
);

    localparam int IW = thb_pkg::IDX_W;
    localparam int CW = thb_pkg::CNT_W;
    localparam int TW = thb_pkg::TIME_W;
    localparam int PW = thb_pkg::PAY_W;
    localparam int AW = thb_pkg::AGE_W;

    logic [TW-1:0] r_time_mem [thb_pkg::DEPTH];
    logic [PW-1:0] r_pay_mem  [thb_pkg::DEPTH];

    thb_pkg::t_state r_state, n_state;
    thb_pkg::t_op    r_op, n_op;
    logic [TW-1:0]   r_key, n_key;
    logic [PW-1:0]   r_pay, n_pay;
    logic [CW-1:0]   r_lo, n_lo;
    logic [CW-1:0]   r_hi, n_hi;
    logic [TW-1:0]   r_before, n_before;
    logic [IW-1:0]   r_pick, n_pick;
    logic [IW-1:0]   r_head, n_head;
    logic [CW-1:0]   r_fill, n_fill;
    logic [AW-1:0]   r_max_age;
    logic [TW-1:0]   r_rd_time;
    logic [PW-1:0]   r_rd_pay;

    logic            r_valid, n_valid;
    logic [1:0]      r_status, n_status;
    logic [TW-1:0]   r_ftime, n_ftime;
    logic [PW-1:0]   r_fpay, n_fpay;
    logic [CW-1:0]   r_count, n_count;
    logic [CW-1:0]   r_removed, n_removed;

    logic            w_we;
    logic [IW-1:0]   w_wa;
    logic [TW-1:0]   w_wt;
    logic [IW-1:0]   w_ra;
    logic [CW-1:0]   w_mid;
    logic [TW:0]     w_prune_diff;
    logic [TW-1:0]   w_after;
    logic [TW-1:0]   w_app_time;

    function automatic logic [IW-1:0] slot_of(input logic [IW-1:0] head,
                                              input logic [CW-1:0] logical);
        return head + logical[IW-1:0];
    endfunction

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_time_mem[w_wa] <= w_wt;
            r_pay_mem[w_wa]  <= r_pay;
        end
        r_rd_time <= r_time_mem[w_ra];
        r_rd_pay  <= r_pay_mem[w_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= thb_pkg::S_IDLE;
            r_head    <= '0;
            r_fill    <= '0;
            r_max_age <= thb_pkg::MAX_AGE_RST;
            r_valid   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_fill  <= n_fill;
            r_valid <= n_valid;
            if (i_cfg_we) begin
                r_max_age <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_op      <= n_op;
        r_key     <= n_key;
        r_pay     <= n_pay;
        r_lo      <= n_lo;
        r_hi      <= n_hi;
        r_before  <= n_before;
        r_pick    <= n_pick;
        r_status  <= n_status;
        r_ftime   <= n_ftime;
        r_fpay    <= n_fpay;
        r_count   <= n_count;
        r_removed <= n_removed;
    end

    assign w_mid        = r_lo + ((r_hi - r_lo) >> 1);
    assign w_prune_diff = {1'b0, i_timestamp} - {{(TW + 1 - AW){1'b0}}, r_max_age};
    assign w_after      = r_rd_time - r_key;
    assign w_app_time   = ((r_fill != '0) && (r_rd_time > r_key)) ? r_rd_time : r_key;

    always_comb begin
        n_state   = r_state;
        n_op      = r_op;
        n_key     = r_key;
        n_pay     = r_pay;
        n_lo      = r_lo;
        n_hi      = r_hi;
        n_before  = r_before;
        n_pick    = r_pick;
        n_head    = r_head;
        n_fill    = r_fill;
        n_valid   = 1'b0;
        n_status  = r_status;
        n_ftime   = r_ftime;
        n_fpay    = r_fpay;
        n_count   = r_count;
        n_removed = r_removed;
        w_we      = 1'b0;
        w_wa      = slot_of(r_head, r_fill);
        w_wt      = w_app_time;
        w_ra      = slot_of(r_head, r_fill - CW'(1));

        unique case (r_state)
            thb_pkg::S_IDLE: begin
                if (start) begin
                    n_op      = thb_pkg::t_op'(i_operation);
                    n_key     = i_timestamp;
                    n_pay     = i_payload;
                    n_lo      = '0;
                    n_hi      = r_fill;
                    n_status  = thb_pkg::STAT_OK;
                    n_ftime   = '0;
                    n_fpay    = '0;
                    n_count   = r_fill;
                    n_removed = '0;
                    unique case (thb_pkg::t_op'(i_operation))
                        thb_pkg::OP_APPEND: begin
                            n_state = (r_fill != '0) ? thb_pkg::S_APP_RD : thb_pkg::S_APP_WR;
                        end
                        thb_pkg::OP_PRUNE: begin
                            if (!w_prune_diff[TW] && (w_prune_diff[TW-1:0] != '0)) begin
                                n_key   = w_prune_diff[TW-1:0];
                                n_state = thb_pkg::S_SRCH;
                            end else begin
                                n_valid = 1'b1;
                            end
                        end
                        thb_pkg::OP_LOOKUP: begin
                            if (r_fill == '0) begin
                                n_status = thb_pkg::STAT_EMPTY;
                                n_valid  = 1'b1;
                            end else begin
                                n_state = thb_pkg::S_SRCH;
                            end
                        end
                        thb_pkg::OP_CLEAR: begin
                            n_removed = r_fill;
                            n_count   = '0;
                            n_fill    = '0;
                            n_head    = '0;
                            n_valid   = 1'b1;
                        end
                        default: ;
                    endcase
                end
            end
            thb_pkg::S_APP_RD: begin
                n_state = thb_pkg::S_APP_WR;
            end
            thb_pkg::S_APP_WR: begin
                w_we = 1'b1;
                if (r_fill == CW'(thb_pkg::DEPTH)) begin
                    w_wa     = r_head;
                    n_head   = r_head + IW'(1);
                    n_status = thb_pkg::STAT_OVERWRITE;
                    n_count  = r_fill;
                end else begin
                    n_fill  = r_fill + CW'(1);
                    n_count = r_fill + CW'(1);
                end
                n_valid = 1'b1;
                n_state = thb_pkg::S_IDLE;
            end
            thb_pkg::S_SRCH: begin
                w_ra = slot_of(r_head, w_mid);
                if (r_lo < r_hi) begin
                    n_state = thb_pkg::S_CMP;
                end else if (r_op == thb_pkg::OP_PRUNE) begin
                    n_head    = slot_of(r_head, r_lo);
                    n_fill    = r_fill - r_lo;
                    n_count   = r_fill - r_lo;
                    n_removed = r_lo;
                    n_valid   = 1'b1;
                    n_state   = thb_pkg::S_IDLE;
                end else if (r_lo >= r_fill) begin
                    n_pick  = IW'(r_fill - CW'(1));
                    n_state = thb_pkg::S_FETCH;
                end else if (r_lo == '0) begin
                    n_pick  = '0;
                    n_state = thb_pkg::S_FETCH;
                end else begin
                    n_state = thb_pkg::S_NEAR_LO;
                end
            end
            thb_pkg::S_CMP: begin
                if (r_rd_time < r_key) begin
                    n_lo = w_mid + CW'(1);
                end else begin
                    n_hi = w_mid;
                end
                n_state = thb_pkg::S_SRCH;
            end
            thb_pkg::S_NEAR_LO: begin
                w_ra    = slot_of(r_head, r_lo - CW'(1));
                n_state = thb_pkg::S_NEAR_HI;
            end
            thb_pkg::S_NEAR_HI: begin
                w_ra     = slot_of(r_head, r_lo);
                n_before = r_key - r_rd_time;
                n_state  = thb_pkg::S_NEAR_SEL;
            end
            thb_pkg::S_NEAR_SEL: begin
                n_pick  = (r_before < w_after) ? IW'(r_lo - CW'(1)) : IW'(r_lo);
                n_state = thb_pkg::S_FETCH;
            end
            thb_pkg::S_FETCH: begin
                w_ra    = r_head + r_pick;
                n_state = thb_pkg::S_REPLY;
            end
            thb_pkg::S_REPLY: begin
                n_ftime = r_rd_time;
                n_fpay  = r_rd_pay;
                n_valid = 1'b1;
                n_state = thb_pkg::S_IDLE;
            end
            default: begin
                n_state = thb_pkg::S_IDLE;
            end
        endcase
    end

    assign busy            = (r_state != thb_pkg::S_IDLE);
    assign o_valid         = r_valid;
    assign o_status        = r_status;
    assign o_found_time    = r_ftime;
    assign o_found_payload = r_fpay;
    assign o_entry_count   = r_count;
    assign o_removed_count = r_removed;

endmodule

>>> sv/thb_checker.sv
// Port-level checker for the timestamp history buffer and its bind to the top level.
module thb_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           start,
    input logic                           busy,
    input logic                           o_valid,
    input logic [thb_pkg::STATUS_W-1:0]   o_status,
    input logic [thb_pkg::TIME_W-1:0]     o_found_time,
    input logic [thb_pkg::PAY_W-1:0]      o_found_payload,
    input logic [thb_pkg::CNT_W-1:0]      o_entry_count,
    input logic [thb_pkg::CNT_W-1:0]      o_removed_count
);

    // Every accepted word either answers at once or keeps the block busy.
    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (o_valid || busy))
        else $error("accepted word neither answered nor started work");

    // The block leaves its busy phase only by showing a result.
    a_done_on_fall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && $fell(busy)) |-> o_valid)
        else $error("busy fell without a result word");

    a_no_result_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result word shown while busy");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_entry_count <= thb_pkg::CNT_W'(thb_pkg::DEPTH)) &&
                     (o_removed_count <= thb_pkg::CNT_W'(thb_pkg::DEPTH))))
        else $error("entry or removed count beyond depth");

    a_empty_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == thb_pkg::STAT_EMPTY)) |->
            ((o_entry_count == '0) && (o_found_time == '0) && (o_found_payload == '0)))
        else $error("empty lookup result carries data");

endmodule

bind timestamp_history_buffer_top thb_checker u_thb_checker (.*);
